// File: rtl/arlt_pkg.sv
// Shared types, codes and range helpers for the address range lookup table.
// Depends on nothing; every other file of the block uses it.
package arlt_pkg;

   localparam int unsigned ARLT_ENTRIES = 16;
   localparam int unsigned ADDR_W       = 32;
   localparam int unsigned TAG_W        = 8;
   localparam int unsigned STATUS_W     = 2;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_WRAP = 2'd3
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] length;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // True when [base, base + len) runs past the top of the address space.
   function automatic logic range_wraps(input logic [ADDR_W-1:0] base,
                                        input logic [ADDR_W-1:0] len);
      logic [ADDR_W-1:0] last_off;
      last_off = len - ADDR_W'(1);
      return (len != '0) && (last_off > ~base);
   endfunction

   // True when addr lies in the entry's range; zero length never hits.
   function automatic logic range_hits(input logic [ADDR_W-1:0] addr,
                                       input entry_type         ent);
      logic [ADDR_W-1:0] off;
      off = addr - ent.base;
      return (addr >= ent.base) && (off < ent.length);
   endfunction

endpackage

// File: rtl/arlt_req_if.sv
// Request channel of the address range lookup table: valid/ready plus one beat.
// Depends on arlt_pkg.
interface arlt_req_if;
   logic                         valid;
   logic                         ready;
   arlt_pkg::kind_type           kind;
   logic [arlt_pkg::ADDR_W-1:0]  address;
   logic [arlt_pkg::ADDR_W-1:0]  length;
   logic [arlt_pkg::TAG_W-1:0]   entry_tag;

   modport source (output valid, kind, address, length, entry_tag, input ready);
   modport sink   (input valid, kind, address, length, entry_tag, output ready);
endinterface

// File: rtl/arlt_rsp_if.sv
// Response channel of the address range lookup table: valid/ready plus one beat.
// Depends on arlt_pkg.
interface arlt_rsp_if;
   logic                        valid;
   logic                        ready;
   arlt_pkg::status_type        status;
   logic [arlt_pkg::TAG_W-1:0]  found_tag;

   modport source (output valid, status, found_tag, input ready);
   modport sink   (input valid, status, found_tag, output ready);
endinterface

// File: rtl/address_range_lookup_table.sv
// Address range lookup table: inserts ranges (base, length, tag), looks up addresses.
// Sequence: accept in ST_IDLE, then ST_SCAN compares slots from 0 up until a hit, the last
// live slot, an empty table or a wrapping insert; ST_DONE posts the result to the response
// register once it is free. A new beat is taken only in ST_IDLE; the single-port scan paces it.
// Reset clears the fill count, the sequencer and the response register; the entry
// memory is not cleared, since only slots below the fill count are ever read.
module address_range_lookup_table #(
   parameter int unsigned ENTRIES = arlt_pkg::ARLT_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   arlt_req_if.sink    req_bus,
   arlt_rsp_if.source  rsp_bus
);
   import arlt_pkg::*;

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Sequencer and latched request beat
   state_type         state_ff, state_in;
   kind_type          kind_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] len_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic              wrap_ff;

   // Fill count: slots 0 .. used-1 are valid, always packed low
   logic [CNT_W-1:0]  used_ff, used_in;

   // Scan pointers: rd_ptr issues reads, cmp_idx tags the data coming back
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              rd_vld_ff, rd_vld_in;

   // Result held between the scan and the response register
   status_type        res_status_ff, res_status_in;
   logic [TAG_W-1:0]  res_tag_ff, res_tag_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;

   logic              req_fire;
   logic              hit, last, full, empty, finish, issue, out_free;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   entry_type         wr_data;
   entry_type         rd_data;

   arlt_entry_ram #(.ENTRIES(ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_idx  (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // A lookup hits on range membership, an insert on an identical base.
   assign hit   = rd_vld_ff && ((kind_ff == KIND_LOOKUP) ? range_hits(addr_ff, rd_data)
                                                        : (rd_data.base == addr_ff));
   assign last  = rd_vld_ff && ((cmp_idx_ff + CNT_W'(1)) == used_ff);
   assign full  = (used_ff == CNT_W'(ENTRIES));
   assign empty = (used_ff == '0);

   // Lowest entry is compared first, so the first hit is the winner: stop there.
   assign finish = (state_ff == ST_SCAN) && (wrap_ff || empty || hit || last);
   assign issue  = (state_ff == ST_SCAN) && !finish && (rd_ptr_ff < used_ff);

   // Write back: overwrite a matching base in place, else append at the fill count.
   assign wr_en   = finish && (kind_ff == KIND_INSERT) && !wrap_ff && (hit || !full);
   assign wr_idx  = hit ? cmp_idx_ff[IDX_W-1:0] : used_ff[IDX_W-1:0];
   assign wr_data = '{base: addr_ff, length: len_ff, tag: tag_ff};

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      rd_ptr_in     = rd_ptr_ff;
      cmp_idx_in    = cmp_idx_ff;
      rd_vld_in     = issue;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;

      if (issue) begin
         rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
         cmp_idx_in = rd_ptr_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_ptr_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_DONE;
               if (kind_ff == KIND_LOOKUP) begin
                  res_status_in = hit ? STATUS_OK : STATUS_MISS;
                  res_tag_in    = hit ? rd_data.tag : '0;
               end else begin
                  res_tag_in = '0;
                  priority if (wrap_ff) begin
                     res_status_in = STATUS_WRAP;
                  end else if (hit || !full) begin
                     res_status_in = STATUS_OK;
                  end else begin
                     res_status_in = STATUS_FULL;
                  end
               end
               // Count only appended slots, not in-place replacements
               if (wr_en && !hit) begin
                  used_in = used_ff + CNT_W'(1);
               end
            end
         end
         ST_DONE: begin
            // Hold the result until the response register frees up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_tag_in    = res_tag_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_bus.kind;
         addr_ff <= req_bus.address;
         len_ff  <= req_bus.length;
         tag_ff  <= req_bus.entry_tag;
         wrap_ff <= (req_bus.kind == KIND_INSERT) &&
                    range_wraps(req_bus.address, req_bus.length);
      end
      rd_ptr_ff     <= rd_ptr_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.found_tag = rsp_tag_ff;

endmodule

// File: rtl/arlt_entry_ram.sv
// Entry store: one write port, one read port with registered read data.
// Depends on arlt_pkg for the entry layout.
module arlt_entry_ram #(
   parameter  int unsigned ENTRIES = arlt_pkg::ARLT_ENTRIES,
   localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  arlt_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_idx,
   output arlt_pkg::entry_type rd_data
);
   import arlt_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for address_range_lookup_table: a range-table predictor, a beat sender
// and a reply checker, driven by named directed and random tests. Needs arlt_pkg and both
// channel interfaces from rtl/, plus the table itself.
module tb_top;
   import arlt_pkg::*;

   // Quiet-cycle budget: well above the long receiver hold-off plus the scan of one beat,
   // so this is many times the slowest correct stretch.
   localparam int unsigned QUIET_LIMIT  = 5000;
   // Settle time after the last reply: long enough for a full 16-entry scan plus posting.
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned MAX_REPORTS  = 10;
   // One past the last address: a range may end here but not beyond.
   localparam logic [ADDR_W:0] SPACE_TOP = {1'b1, {ADDR_W{1'b0}}};

   typedef struct packed {
      status_type        status;
      logic [TAG_W-1:0]  found_tag;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   arlt_req_if req_bus ();
   arlt_rsp_if rsp_bus ();

   address_range_lookup_table u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predicted table contents; live slots are always the lowest-numbered ones.
   bit              slot_live [ARLT_ENTRIES];
   bit [ADDR_W-1:0] slot_base [ARLT_ENTRIES];
   bit [ADDR_W-1:0] slot_len  [ARLT_ENTRIES];
   bit [TAG_W-1:0]  slot_tag  [ARLT_ENTRIES];
   int unsigned     slot_fill;

   table_reply_type due_replies [$];

   int unsigned     send_gap_pct;
   int unsigned     recv_gap_pct;
   int unsigned     hold_request;
   int unsigned     hold_left;
   int unsigned     mismatch_count;
   int unsigned     quiet_cycles;
   table_reply_type want_reply;
   table_reply_type got_reply;

   initial begin
      forever #2 clock = ~clock;
   end

   // Apply one accepted beat to the predicted table and return the reply it must produce.
   function automatic table_reply_type range_table_step(input kind_type         kind,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [ADDR_W-1:0] len,
                                                        input logic [TAG_W-1:0]  tag);
      table_reply_type   reply;
      int                hit;
      logic [ADDR_W-1:0] off;
      reply.status    = STATUS_OK;
      reply.found_tag = '0;
      hit             = -1;
      if (kind == KIND_LOOKUP) begin
         // Lowest-numbered live slot holding the address wins; zero length never holds one.
         for (int i = 0; i < ARLT_ENTRIES; i++) begin
            off = addr - slot_base[i];
            if (hit < 0 && slot_live[i] && addr >= slot_base[i] && off < slot_len[i])
               hit = i;
         end
         if (hit < 0) begin
            reply.status = STATUS_MISS;
         end else begin
            reply.found_tag = slot_tag[hit];
         end
      end else if (({1'b0, addr} + {1'b0, len}) > SPACE_TOP) begin
         // Range runs past the top: reject, touch nothing, even for a known base.
         reply.status = STATUS_WRAP;
      end else begin
         for (int i = 0; i < ARLT_ENTRIES; i++) begin
            if (hit < 0 && slot_live[i] && slot_base[i] == addr)
               hit = i;
         end
         if (hit >= 0) begin
            // Known base: rewrite in place, allowed even when the table is full.
            slot_len[hit] = len;
            slot_tag[hit] = tag;
         end else if (slot_fill >= ARLT_ENTRIES) begin
            reply.status = STATUS_FULL;
         end else begin
            slot_live[slot_fill] = 1'b1;
            slot_base[slot_fill] = addr;
            slot_len[slot_fill]  = len;
            slot_tag[slot_fill]  = tag;
            slot_fill++;
         end
      end
      return reply;
   endfunction

   // Offer one beat, idling first at the current sender rate; record its reply once taken.
   task automatic send_beat(input kind_type         kind,
                            input logic [ADDR_W-1:0] addr,
                            input logic [ADDR_W-1:0] len,
                            input logic [TAG_W-1:0]  tag);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.address   <= addr;
      req_bus.length    <= len;
      req_bus.entry_tag <= tag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      due_replies.insert(due_replies.size(), range_table_step(kind, addr, len, tag));
   endtask

   // Drop valid and hold off until every predicted reply has come back.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed traffic steered at live ranges, with some wraps, new bases and noise.
   task automatic random_traffic(input int unsigned count);
      int unsigned       pick;
      int unsigned       k;
      kind_type          kind;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] len;
      logic [ADDR_W-1:0] off;
      logic [TAG_W-1:0]  tag;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         kind = KIND_INSERT;
         addr = $urandom;
         len  = $urandom;
         tag  = TAG_W'($urandom);
         if (pick < 50) begin
            kind = KIND_LOOKUP;
            if (slot_fill != 0 && $urandom_range(0, 9) < 7) begin
               // aim at a live range: first byte, last byte, one past, or inside
               k = $urandom_range(0, slot_fill - 1);
               case ($urandom_range(0, 3))
                  0: off = '0;
                  1: off = slot_len[k] - ADDR_W'(1);
                  2: off = slot_len[k];
                  default: off = (slot_len[k] == '0) ? '0 : $urandom_range(0, slot_len[k] - 1);
               endcase
               addr = slot_base[k] + off;
            end
         end else if (pick < 80 && slot_fill != 0) begin
            // rewrite a known base; a raw length here usually wraps
            k    = $urandom_range(0, slot_fill - 1);
            addr = slot_base[k];
            case ($urandom_range(0, 9))
               0: len = '0;
               1: ;
               default: len = $urandom_range(1, 'h1000);
            endcase
         end else if (pick < 88) begin
            // end just past the top of the address space
            len = ~addr + ADDR_W'(2) + ADDR_W'($urandom_range(0, 'hFF));
         end else if (pick < 95) begin
            len = $urandom_range(1, 'h800);
         end else begin
            kind = kind_type'($urandom_range(0, 1));
         end
         send_beat(kind, addr, len, tag);
      end
   endtask

   task automatic test_empty_table();
      send_beat(KIND_LOOKUP, '0, '1, '1);
      send_beat(KIND_LOOKUP, '1, '0, '0);
      send_beat(KIND_INSERT, 32'hFFFF_FFF0, 32'h0000_0020, 8'h77);
      send_beat(KIND_LOOKUP, 32'hFFFF_FFF8, '0, '0);
   endtask

   task automatic test_range_edges();
      send_beat(KIND_INSERT, 32'h0000_0000, 32'h0000_0100, 8'h00);
      // ends exactly at the top: accepted
      send_beat(KIND_INSERT, 32'hFFFF_FF00, 32'h0000_0100, 8'hFF);
      // zero length: stored, never hit
      send_beat(KIND_INSERT, 32'h0000_1000, 32'h0000_0000, 8'h5A);
      send_beat(KIND_LOOKUP, 32'h0000_1000, '0, '0);
      send_beat(KIND_LOOKUP, 32'h0000_0000, '0, '0);
      send_beat(KIND_LOOKUP, 32'h0000_00FF, '0, '0);
      send_beat(KIND_LOOKUP, 32'h0000_0100, '0, '0);
      send_beat(KIND_LOOKUP, 32'hFFFF_FF00, '0, '0);
      send_beat(KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0);
   endtask

   task automatic test_same_base();
      // longest length that still fits from base zero
      send_beat(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 8'h3C);
      send_beat(KIND_LOOKUP, 32'h8000_0000, '0, '0);
      // wrapping rewrite of a known base must leave it alone
      send_beat(KIND_INSERT, 32'hFFFF_FF00, 32'h0000_0101, 8'h11);
      send_beat(KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0);
      send_beat(KIND_INSERT, 32'h0000_0000, 32'h0000_0010, 8'hA5);
      send_beat(KIND_LOOKUP, 32'h0000_000F, '0, '0);
      send_beat(KIND_LOOKUP, 32'h0000_0010, '0, '0);
   endtask

   task automatic test_overlap();
      send_beat(KIND_INSERT, 32'h0000_2000, 32'h0000_1000, 8'h11);
      send_beat(KIND_INSERT, 32'h0000_2800, 32'h0000_1000, 8'h22);
      send_beat(KIND_LOOKUP, 32'h0000_2900, '0, '0);
      send_beat(KIND_LOOKUP, 32'h0000_3500, '0, '0);
   endtask

   task automatic test_full_table();
      while (slot_fill < ARLT_ENTRIES)
         send_beat(KIND_INSERT, $urandom, $urandom_range(1, 'h400), TAG_W'($urandom));
      // new base on a full table is refused; a known base is still rewritten
      send_beat(KIND_INSERT, $urandom, 32'h0000_0040, 8'hC3);
      send_beat(KIND_INSERT, slot_base[ARLT_ENTRIES-1], 32'h0000_0040, 8'h96);
      send_beat(KIND_LOOKUP, slot_base[ARLT_ENTRIES-1] + 32'h3F, '0, '0);
   endtask

   task automatic test_backpressure();
      // stall the receiver for a long stretch while beats keep coming
      hold_request = HOLD_CYCLES;
      random_traffic(60);
   endtask

   task automatic test_drain_pause();
      random_traffic(20);
      wait_for_drain();
      random_traffic(20);
   endtask

   // Reply checker and receiver pacing: compare each reply beat with the oldest prediction.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got_reply.status    = rsp_bus.status;
            got_reply.found_tag = rsp_bus.found_tag;
            if (due_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected reply beat: status=%0d tag=%h",
                           got_reply.status, got_reply.found_tag);
            end else begin
               want_reply = due_replies.pop_front();
               if (got_reply !== want_reply) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("reply mismatch: expected status=%0d tag=%h, got status=%0d tag=%h",
                              want_reply.status, want_reply.found_tag,
                              got_reply.status, got_reply.found_tag);
               end
            end
         end
         // pick up a hold-off request and count it down here
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
         end
      end
   end

   // Watchdog: end the run when no beat moves on either channel for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= KIND_INSERT;
      req_bus.address   <= '0;
      req_bus.length    <= '0;
      req_bus.entry_tag <= '0;
      send_gap_pct   = 31;
      recv_gap_pct   = 55;
      hold_request   = 0;
      hold_left      = 0;
      mismatch_count = 0;
      slot_fill      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_range_edges();
      test_same_base();
      test_overlap();
      random_traffic(350);

      // swap the idle rates
      send_gap_pct = 55;
      recv_gap_pct = 31;
      random_traffic(350);

      // no idling from here on
      send_gap_pct = 0;
      recv_gap_pct = 0;
      test_full_table();
      test_backpressure();
      test_drain_pause();
      random_traffic(350);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_replies.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
